// File: rtl/cbaf_pkg.sv
// ----------------------------------------------------------------------------
// cbaf_pkg: shared types and constants of the Bezier flattener
// Widths, depth limits and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package cbaf_pkg;
  localparam int MaxDepth   = 6;
  localparam int CoordWidth = 24;
  localparam int IndexWidth = 20;
  localparam int TolWidth   = 23;
  localparam int LevelWidth = 3;
  localparam int SlotWidth  = 3;
  localparam int LeafWidth  = 7;
  localparam int RowWidth   = 8 * CoordWidth + LevelWidth;
  localparam int DiffWidth  = CoordWidth + 3;
  localparam int SqWidth    = 2 * DiffWidth + 1;
  localparam int TolSqWidth = 2 * TolWidth;
  localparam logic [TolWidth-1:0] TolReset = TolWidth'(51);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SQUARE,
    ST_DECIDE,
    ST_EMIT,
    ST_POP
  } state_t;

  typedef logic signed [CoordWidth-1:0] coord_t;

  function automatic coord_t half_sum(input coord_t a, input coord_t b);
    logic signed [CoordWidth:0] s;
    s = {a[CoordWidth-1], a} + {b[CoordWidth-1], b};
    return coord_t'(s >>> 1);
  endfunction
endpackage
`default_nettype wire

// File: rtl/cbaf_stack_ram.sv
// ----------------------------------------------------------------------------
// cbaf_stack_ram: pending-piece stack memory
// One write port and one registered read port over the pushed halves.
// ----------------------------------------------------------------------------
`default_nettype none
module cbaf_stack_ram
  import cbaf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [SlotWidth-1:0] wr_addr,
  input  wire logic [RowWidth-1:0]  wr_data,
  input  wire logic [SlotWidth-1:0] rd_addr,
  output logic      [RowWidth-1:0]  rd_data
);
  logic [RowWidth-1:0] mem [MaxDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/cubic_bezier_adaptive_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_adaptive_flattener: adaptive de Casteljau curve flattener
// Splits one cubic segment depth-first into line leaves and streams them out.
// ----------------------------------------------------------------------------
// One segment is taken at a time. Each piece is split and tested in three steps
// (midpoint logic, squaring, compare); a flat piece then hands its leaf to the
// output register, waiting while the output stalls, and, if more remain, the
// next piece is popped from the stack memory. A new segment is taken only once
// the last leaf of the previous one has been handed to the output register.
// in_tdata fields, lowest bit up: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x,
// p3_y; in_tuser holds continue_path. out_tdata: first_vertex_index, start_x,
// start_y, mid_x, mid_y, end_x, end_y; out_tuser: has_start; out_tlast marks
// the last leaf of the segment.
`default_nettype none
module cubic_bezier_adaptive_flattener
  import cbaf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [22:0]   cfg_wdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  wire logic [191:0]  in_tdata,
  // continue_path
  input  wire logic          in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // first_vertex_index, start_x, start_y, mid_x, mid_y, end_x, end_y
  output logic [167:0]       out_tdata,
  // has_start
  output logic               out_tuser,
  output logic               out_tlast
);
  state_t state_r, state_nxt;
  logic [TolWidth-1:0]    tol_r;
  coord_t                 w_r [8];
  coord_t                 w_nxt [8];
  logic [LevelWidth-1:0]  lvl_r, lvl_nxt;
  logic [SlotWidth-1:0]   sp_r, sp_nxt;
  logic                   cont_r, cont_nxt;
  logic [IndexWidth-1:0]  vcnt_r, vcnt_nxt;
  logic [LeafWidth-1:0]   nleaf_r, nleaf_nxt;
  coord_t q01 [2], q12 [2], q23 [2], q012 [2], q123 [2], q0123 [2];
  coord_t m_r [2], q123_r [2], q23_r [2], q01_r [2], q012_r [2];
  logic signed [DiffWidth-1:0] dx_r, dy_r;
  logic [SqWidth-1:0]     d2_r;
  logic [TolSqWidth-1:0]  tol2_r;
  logic                   leaf_w;
  logic                   wr_en;
  logic [RowWidth-1:0]    wr_data, rd_data;
  logic [167:0]           odata_nxt;
  logic                   emit;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q01[k]   = half_sum(w_r[k], w_r[2 + k]);
      q12[k]   = half_sum(w_r[2 + k], w_r[4 + k]);
      q23[k]   = half_sum(w_r[4 + k], w_r[6 + k]);
      q012[k]  = half_sum(q01[k], q12[k]);
      q123[k]  = half_sum(q12[k], q23[k]);
      q0123[k] = half_sum(q012[k], q123[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SPLIT) begin
      for (int k = 0; k < 2; k++) begin
        m_r[k]    <= q0123[k];
        q123_r[k] <= q123[k];
        q23_r[k]  <= q23[k];
        q01_r[k]  <= q01[k];
        q012_r[k] <= q012[k];
      end
      dx_r <= DiffWidth'(q0123[0]) - DiffWidth'(q12[0]);
      dy_r <= DiffWidth'(q0123[1]) - DiffWidth'(q12[1]);
    end
    if (state_r == ST_SQUARE) begin
      d2_r <= SqWidth'(dx_r * dx_r) + SqWidth'(dy_r * dy_r);
    end
    tol2_r <= tol_r * tol_r;
  end

  assign leaf_w = (SqWidth'(tol2_r) > d2_r) || (lvl_r >= LevelWidth'(MaxDepth));

  assign wr_en   = (state_r == ST_DECIDE) && !leaf_w;
  assign wr_data = {lvl_r + LevelWidth'(1), w_r[7], w_r[6], q23_r[1], q23_r[0],
                    q123_r[1], q123_r[0], m_r[1], m_r[0]};

  cbaf_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sp_r),
    .wr_data (wr_data),
    .rd_addr (sp_r - SlotWidth'(1)),
    .rd_data (rd_data)
  );

  assign emit = (state_r == ST_EMIT) && !(out_tvalid && !out_tready);
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    lvl_nxt   = lvl_r;
    sp_nxt    = sp_r;
    cont_nxt  = cont_r;
    vcnt_nxt  = vcnt_r;
    nleaf_nxt = nleaf_r;
    odata_nxt = {4'b0, w_r[7], w_r[6], m_r[1], m_r[0],
                 cont_r ? coord_t'(0) : w_r[1], cont_r ? coord_t'(0) : w_r[0], vcnt_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 8; i++) begin
            w_nxt[i] = coord_t'(in_tdata[i*CoordWidth +: CoordWidth]);
          end
          lvl_nxt   = '0;
          sp_nxt    = '0;
          nleaf_nxt = '0;
          cont_nxt  = in_tuser;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT:  state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (leaf_w) begin
          state_nxt = ST_EMIT;
        end else begin
          w_nxt[2] = q01_r[0];  w_nxt[3] = q01_r[1];
          w_nxt[4] = q012_r[0]; w_nxt[5] = q012_r[1];
          w_nxt[6] = m_r[0];    w_nxt[7] = m_r[1];
          lvl_nxt   = lvl_r + LevelWidth'(1);
          sp_nxt    = sp_r + SlotWidth'(1);
          state_nxt = ST_SPLIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          vcnt_nxt  = vcnt_r + (cont_r ? IndexWidth'(2) : IndexWidth'(3));
          cont_nxt  = 1'b1;
          nleaf_nxt = nleaf_r + LeafWidth'(1);
          if (sp_r == '0 || nleaf_r == LeafWidth'(63)) begin
            state_nxt = ST_IDLE;
          end else begin
            sp_nxt    = sp_r - SlotWidth'(1);
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        for (int i = 0; i < 8; i++) begin
          w_nxt[i] = coord_t'(rd_data[i*CoordWidth +: CoordWidth]);
        end
        lvl_nxt   = rd_data[8*CoordWidth +: LevelWidth];
        state_nxt = ST_SPLIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tol_r      <= TolReset;
      lvl_r      <= '0;
      sp_r       <= '0;
      cont_r     <= 1'b0;
      vcnt_r     <= '0;
      nleaf_r    <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      lvl_r   <= lvl_nxt;
      sp_r    <= sp_nxt;
      cont_r  <= cont_nxt;
      vcnt_r  <= vcnt_nxt;
      nleaf_r <= nleaf_nxt;
      if (emit) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (emit) begin
      out_tdata <= odata_nxt;
      out_tuser <= !cont_r;
      out_tlast <= (sp_r == '0);
    end
  end
endmodule
`default_nettype wire
